/* src/rocca_aead_core_macros.svh */
// Assertion macros shared by the Rocca core.
`ifndef ROCCA_AEAD_CORE_MACROS_SVH
`define ROCCA_AEAD_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ROCCA_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define ROCCA_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`endif

/* src/rocca_pkg.sv */
// Types, constants and AES round function for the Rocca core.
package rocca_pkg;

  typedef enum logic [2:0] {
    CMD_INIT     = 3'd0,
    CMD_AD       = 3'd1,
    CMD_ENCRYPT  = 3'd2,
    CMD_DECRYPT  = 3'd3,
    CMD_FINALIZE = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT_RUN,
    ST_FIN_RUN,
    ST_OUT
  } state_t;

  localparam int unsigned NUM_REGS = 6;
  localparam int unsigned REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_KEY0  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEY1  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KEY2  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KEY3  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_NONCE_LO = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_NONCE_HI = 3'd5;

  localparam logic [127:0] Z0 = {32'h428a2f98, 32'hd728ae22, 32'h71374491, 32'h23ef65cd};
  localparam logic [127:0] Z1 = {32'hb5c0fbcf, 32'hec4d3b2f, 32'he9b5dba5, 32'h8189dbbc};
  localparam logic [31:0] BLOCK_BYTES = 32'd32;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_TAG  = 1'b1;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load_init;   // load the init state
    logic run_round;   // one round with the selected block inputs
    logic fin_load;    // copy the state into the finalize shadow
    logic fin_round;   // one round on the shadow
    logic msg_step;    // encrypt or decrypt the accepted block
    logic ad_step;     // absorb the accepted block
    logic decrypt;     // feed plaintext recovered from the block
    logic capture_out; // capture data result
    logic capture_tag; // capture tag result
  } dp_cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // One AES round on a 128-bit word; byte i sits at bits 8i+7:8i.
  function automatic logic [127:0] aes_round(input logic [127:0] m, input logic [127:0] k);
    logic [7:0] t [16];
    logic [127:0] o;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r + 4*c] = SBOX[m[8*(r + 4*((c + r) % 4)) +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      o[8*(4*c)   +: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      o[8*(4*c+1) +: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      o[8*(4*c+2) +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      o[8*(4*c+3) +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    aes_round = o ^ k;
  endfunction

endpackage

/* src/rocca_datapath.sv */
// Rocca state registers, round logic, counters and result register.
module rocca_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rocca_pkg::dp_cmd_t   cmd,
  input  logic [255:0]         blk,
  input  logic [255:0]         key,
  input  logic [127:0]         nonce,
  output logic                 res_kind,
  output logic [255:0]         res_data
);

  logic [127:0] s_r   [8];
  logic [127:0] s_nxt [8];
  logic [127:0] f_r   [8];
  logic [127:0] f_nxt [8];
  logic [31:0]  ad_cnt_r, ad_cnt_nxt;
  logic [31:0]  msg_cnt_r, msg_cnt_nxt;
  logic         res_kind_r;
  logic [255:0] res_data_r;

  logic [127:0] rin [8];
  logic [127:0] rout [8];
  logic [127:0] x0, x1, y0, y1, kx0, kx1, tag;

  // Round input: the finalize shadow or the live state.
  always_comb begin
    for (int i = 0; i < 8; i++) rin[i] = cmd.fin_round ? f_r[i] : s_r[i];
  end

  assign kx0 = blk[127:0] ^ rocca_pkg::aes_round(s_r[1], s_r[5]);
  assign kx1 = blk[255:128] ^ rocca_pkg::aes_round(s_r[0] ^ s_r[4], s_r[2]);

  always_comb begin
    priority if (cmd.fin_round) begin
      x0 = {93'd0, ad_cnt_r, 3'd0};
      x1 = {93'd0, msg_cnt_r, 3'd0};
    end else if (cmd.load_init || !(cmd.ad_step || cmd.msg_step)) begin
      x0 = rocca_pkg::Z0;
      x1 = rocca_pkg::Z1;
    end else if (cmd.decrypt) begin
      x0 = kx0;
      x1 = kx1;
    end else begin
      x0 = blk[127:0];
      x1 = blk[255:128];
    end
  end

  always_comb begin
    y0 = x0;
    y1 = x1;
    rout[0] = rin[7] ^ y0;
    rout[1] = rocca_pkg::aes_round(rin[0], rin[7]);
    rout[2] = rin[1] ^ rin[6];
    rout[3] = rocca_pkg::aes_round(rin[2], rin[1]);
    rout[4] = rin[3] ^ y1;
    rout[5] = rocca_pkg::aes_round(rin[4], rin[3]);
    rout[6] = rocca_pkg::aes_round(rin[5], rin[4]);
    rout[7] = rin[0] ^ rin[6];
  end

  always_comb begin
    tag = '0;
    for (int i = 0; i < 8; i++) tag = tag ^ f_r[i];
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      s_nxt[i] = s_r[i];
      f_nxt[i] = f_r[i];
    end
    ad_cnt_nxt  = ad_cnt_r;
    msg_cnt_nxt = msg_cnt_r;
    if (cmd.load_init) begin
      s_nxt[0] = key[255:128];
      s_nxt[1] = nonce;
      s_nxt[2] = rocca_pkg::Z0;
      s_nxt[3] = rocca_pkg::Z1;
      s_nxt[4] = nonce ^ key[255:128];
      s_nxt[5] = '0;
      s_nxt[6] = key[127:0];
      s_nxt[7] = '0;
      ad_cnt_nxt  = '0;
      msg_cnt_nxt = '0;
    end else if (cmd.run_round) begin
      for (int i = 0; i < 8; i++) s_nxt[i] = rout[i];
      if (cmd.ad_step) ad_cnt_nxt = ad_cnt_r + rocca_pkg::BLOCK_BYTES;
      if (cmd.msg_step) msg_cnt_nxt = msg_cnt_r + rocca_pkg::BLOCK_BYTES;
    end
    if (cmd.fin_load) begin
      for (int i = 0; i < 8; i++) f_nxt[i] = s_r[i];
    end else if (cmd.fin_round) begin
      for (int i = 0; i < 8; i++) f_nxt[i] = rout[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) s_r[i] <= '0;
      ad_cnt_r  <= '0;
      msg_cnt_r <= '0;
    end else begin
      for (int i = 0; i < 8; i++) s_r[i] <= s_nxt[i];
      ad_cnt_r  <= ad_cnt_nxt;
      msg_cnt_r <= msg_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 8; i++) f_r[i] <= f_nxt[i];
    if (cmd.capture_out) begin
      res_kind_r <= rocca_pkg::KIND_DATA;
      res_data_r <= {kx1, kx0};
    end else if (cmd.capture_tag) begin
      res_kind_r <= rocca_pkg::KIND_TAG;
      res_data_r <= {128'd0, tag};
    end
  end

  assign res_kind = res_kind_r;
  assign res_data = res_data_r;

endmodule

/* src/rocca_ctrl.sv */
// Rocca controller: command decode, round counter and output handshake.
module rocca_ctrl #(
  parameter int unsigned INIT_ROUNDS = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic [2:0]         command,
  input  logic               out_fire,
  output logic               in_ready,
  output logic               out_valid,
  output rocca_pkg::dp_cmd_t cmd
);

  localparam int unsigned CW = $clog2(INIT_ROUNDS + 1);

  rocca_pkg::state_t st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic last;

  assign last = (cnt_r == CW'(INIT_ROUNDS - 1));

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    unique case (st_r)
      rocca_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (in_fire) begin
          unique case (command)
            rocca_pkg::CMD_INIT:     st_nxt = rocca_pkg::ST_INIT_RUN;
            rocca_pkg::CMD_ENCRYPT,
            rocca_pkg::CMD_DECRYPT:  st_nxt = rocca_pkg::ST_OUT;
            rocca_pkg::CMD_FINALIZE: st_nxt = rocca_pkg::ST_FIN_RUN;
            default:                 st_nxt = rocca_pkg::ST_IDLE;
          endcase
        end
      end
      rocca_pkg::ST_INIT_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (last) st_nxt = rocca_pkg::ST_IDLE;
      end
      rocca_pkg::ST_FIN_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(INIT_ROUNDS)) st_nxt = rocca_pkg::ST_OUT;
      end
      rocca_pkg::ST_OUT: begin
        if (out_fire) st_nxt = rocca_pkg::ST_IDLE;
      end
      default: st_nxt = rocca_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready  = (st_r == rocca_pkg::ST_IDLE);
    out_valid = (st_r == rocca_pkg::ST_OUT);
    unique case (st_r)
      rocca_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (command)
            rocca_pkg::CMD_INIT: cmd.load_init = 1'b1;
            rocca_pkg::CMD_AD: begin
              cmd.run_round = 1'b1;
              cmd.ad_step   = 1'b1;
            end
            rocca_pkg::CMD_ENCRYPT, rocca_pkg::CMD_DECRYPT: begin
              cmd.run_round   = 1'b1;
              cmd.msg_step    = 1'b1;
              cmd.decrypt     = (command == rocca_pkg::CMD_DECRYPT);
              cmd.capture_out = 1'b1;
            end
            rocca_pkg::CMD_FINALIZE: cmd.fin_load = 1'b1;
            default: ;
          endcase
        end
      end
      rocca_pkg::ST_INIT_RUN: cmd.run_round = 1'b1;
      rocca_pkg::ST_FIN_RUN: begin
        // Rounds run while the count is below the limit; the last cycle takes the tag.
        if (cnt_r == CW'(INIT_ROUNDS)) cmd.capture_tag = 1'b1;
        else cmd.fin_round = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= rocca_pkg::ST_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* src/rocca_aead_core.sv */
// Rocca AEAD core: one 32-byte block per transaction, one state round per cycle while a command runs its rounds.
// Absorb and encrypt/decrypt run their round in the accepting cycle; encrypt/decrypt then wait
// for the output transaction. Init loads the state and runs INIT_ROUNDS rounds; finalize copies
// the state to a shadow, runs INIT_ROUNDS rounds on it in the single shared round unit, then takes its tag.
// One transaction is in flight at a time. Synchronous active-low reset clears
// the state, counters, key and nonce registers to zero.
`include "rocca_aead_core_macros.svh"
module rocca_aead_core #(
  parameter int unsigned INIT_ROUNDS = 20
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [255:0] in_tdata,   // block_word0..block_word3
  input  logic [2:0]   in_tuser,   // command
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [255:0] out_tdata,  // out_word0..out_word3
  output logic         out_tuser   // result_kind
);

  logic [63:0] cfg_r [rocca_pkg::NUM_REGS];
  logic in_fire, out_fire;
  rocca_pkg::dp_cmd_t cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rocca_pkg::NUM_REGS; i++) cfg_r[i] <= '0;
    end else if (cfg_we && (cfg_index < 3'(rocca_pkg::NUM_REGS))) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  rocca_ctrl #(.INIT_ROUNDS(INIT_ROUNDS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .command  (in_tuser),
    .out_fire (out_fire),
    .in_ready (in_tready),
    .out_valid(out_tvalid),
    .cmd      (cmd)
  );

  rocca_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .blk      (in_tdata),
    .key      ({cfg_r[rocca_pkg::REG_KEY3], cfg_r[rocca_pkg::REG_KEY2],
                cfg_r[rocca_pkg::REG_KEY1], cfg_r[rocca_pkg::REG_KEY0]}),
    .nonce    ({cfg_r[rocca_pkg::REG_NONCE_HI], cfg_r[rocca_pkg::REG_NONCE_LO]}),
    .res_kind (out_tuser),
    .res_data (out_tdata)
  );

  `ROCCA_ASSERT_IMP(a_no_accept_busy, clk, rst_n, out_tvalid, !in_tready,
    "input accepted while a result waits")
  `ROCCA_ASSERT_NEXT(a_crypt_result, clk, rst_n,
    in_fire && (in_tuser == rocca_pkg::CMD_ENCRYPT || in_tuser == rocca_pkg::CMD_DECRYPT),
    out_tvalid && !out_tuser, "data result missing after encrypt or decrypt")
  `ROCCA_ASSERT_IMP(a_tag_upper_zero, clk, rst_n, out_tvalid && out_tuser,
    out_tdata[255:128] == '0, "tag upper words not zero")

endmodule

/* verif/tb_rocca_aead_core.sv */
// Self-checking testbench for the Rocca AEAD core: predicted data blocks and tags versus the RTL.
module tb_rocca_aead_core;

  localparam int unsigned ROUNDS = 20;
  localparam int unsigned IDLE_LIMIT = 20000;

  typedef struct packed {
    logic         kind;
    logic [255:0] data;
  } cipher_result_t;

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [63:0]  cfg_data;
  logic         in_tvalid;
  logic         in_tready;
  logic [255:0] in_tdata;   // block_word0..block_word3
  logic [2:0]   in_tuser;   // command
  logic         out_tvalid;
  logic         out_tready;
  logic [255:0] out_tdata;  // out_word0..out_word3
  logic         out_tuser;  // result_kind

  rocca_aead_core #(.INIT_ROUNDS(ROUNDS)) u_top (.*);

  // Predictor copy of the key/nonce registers, the cipher state and the counters.
  logic [63:0]  key_nonce [6];
  logic [127:0] rstate [8];
  logic [31:0]  ad_bytes;
  logic [31:0]  msg_bytes;

  cipher_result_t pending_results [$];
  int  error_count = 0;
  int  idle_cycles = 0;
  int  stall_left = 0;
  bit  allow_stall;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] gmul2(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] aes_step(input logic [127:0] m, input logic [127:0] k);
    logic [7:0] sb [16];
    logic [127:0] mixed;
    logic [7:0] b0, b1, b2, b3;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sb[r + 4*c] = rocca_pkg::SBOX[m[8*(r + 4*((c + r) & 3)) +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      b0 = sb[4*c]; b1 = sb[4*c+1]; b2 = sb[4*c+2]; b3 = sb[4*c+3];
      mixed[32*c      +: 8] = gmul2(b0) ^ gmul2(b1) ^ b1 ^ b2 ^ b3;
      mixed[32*c + 8  +: 8] = b0 ^ gmul2(b1) ^ gmul2(b2) ^ b2 ^ b3;
      mixed[32*c + 16 +: 8] = b0 ^ b1 ^ gmul2(b2) ^ gmul2(b3) ^ b3;
      mixed[32*c + 24 +: 8] = gmul2(b0) ^ b0 ^ b1 ^ b2 ^ gmul2(b3);
    end
    return mixed ^ k;
  endfunction

  task automatic state_round(inout logic [127:0] s [8], input logic [127:0] x0,
                             input logic [127:0] x1);
    logic [127:0] n [8];
    n[0] = s[7] ^ x0;
    n[1] = aes_step(s[0], s[7]);
    n[2] = s[1] ^ s[6];
    n[3] = aes_step(s[2], s[1]);
    n[4] = s[3] ^ x1;
    n[5] = aes_step(s[4], s[3]);
    n[6] = aes_step(s[5], s[4]);
    n[7] = s[0] ^ s[6];
    s = n;
  endtask

  // Updates the predicted state for one command and queues any result it yields.
  task automatic predict_block(input logic [2:0] cmd, input logic [255:0] blk);
    logic [127:0] x0, x1, y0, y1, k1, nonce, tag;
    logic [127:0] shadow [8];
    cipher_result_t res;
    x0 = blk[127:0];
    x1 = blk[255:128];
    case (cmd)
      rocca_pkg::CMD_INIT: begin
        k1 = {key_nonce[rocca_pkg::REG_KEY3], key_nonce[rocca_pkg::REG_KEY2]};
        nonce = {key_nonce[rocca_pkg::REG_NONCE_HI], key_nonce[rocca_pkg::REG_NONCE_LO]};
        rstate[0] = k1; rstate[1] = nonce;
        rstate[2] = rocca_pkg::Z0; rstate[3] = rocca_pkg::Z1;
        rstate[4] = nonce ^ k1; rstate[5] = '0;
        rstate[6] = {key_nonce[rocca_pkg::REG_KEY1], key_nonce[rocca_pkg::REG_KEY0]};
        rstate[7] = '0;
        for (int i = 0; i < ROUNDS; i++) state_round(rstate, rocca_pkg::Z0, rocca_pkg::Z1);
        ad_bytes = '0;
        msg_bytes = '0;
      end
      rocca_pkg::CMD_AD: begin
        state_round(rstate, x0, x1);
        ad_bytes += rocca_pkg::BLOCK_BYTES;
      end
      rocca_pkg::CMD_ENCRYPT, rocca_pkg::CMD_DECRYPT: begin
        y0 = x0 ^ aes_step(rstate[1], rstate[5]);
        y1 = x1 ^ aes_step(rstate[0] ^ rstate[4], rstate[2]);
        if (cmd == rocca_pkg::CMD_ENCRYPT) state_round(rstate, x0, x1);
        else state_round(rstate, y0, y1);
        msg_bytes += rocca_pkg::BLOCK_BYTES;
        res.kind = rocca_pkg::KIND_DATA;
        res.data = {y1, y0};
        pending_results.push_back(res);
      end
      rocca_pkg::CMD_FINALIZE: begin
        shadow = rstate;
        for (int i = 0; i < ROUNDS; i++) begin
          state_round(shadow, {93'd0, ad_bytes, 3'd0}, {93'd0, msg_bytes, 3'd0});
        end
        tag = '0;
        for (int i = 0; i < 8; i++) tag ^= shadow[i];
        res.kind = rocca_pkg::KIND_TAG;
        res.data = {128'd0, tag};
        pending_results.push_back(res);
      end
      default: ;
    endcase
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  function automatic logic [255:0] random_block();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // Valid stays high after an accept so that back-to-back transactions need no gap.
  task automatic send_block(input logic [2:0] cmd, input logic [255:0] blk);
    int gap;
    gap = allow_stall ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= blk;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_block(cmd, blk);
  endtask

  // Lets the block drain, including a finalize or init still running its rounds.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (ROUNDS + 8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    key_nonce[idx] = value;
  endtask

  task automatic load_key_nonce(input logic [63:0] fill, input bit use_random);
    for (int i = 0; i < rocca_pkg::NUM_REGS; i++) begin
      write_reg(3'(i), use_random ? {$urandom, $urandom} : fill);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_before_init();
    send_block(rocca_pkg::CMD_AD, '1);
    send_block(rocca_pkg::CMD_ENCRYPT, '0);
    send_block(rocca_pkg::CMD_DECRYPT, '1);
    send_block(rocca_pkg::CMD_FINALIZE, '0);
  endtask

  task automatic test_directed();
    wait_drained();
    load_key_nonce('0, 1'b0);
    send_block(rocca_pkg::CMD_INIT, '0);
    send_block(rocca_pkg::CMD_AD, '0);
    send_block(rocca_pkg::CMD_AD, '1);
    send_block(rocca_pkg::CMD_ENCRYPT, '1);
    send_block(rocca_pkg::CMD_DECRYPT, '0);
    send_block(rocca_pkg::CMD_FINALIZE, '1);
    send_block(rocca_pkg::CMD_FINALIZE, '0);   // repeated finalize yields the same tag
    send_block(3'd5, '1);                      // unknown commands are ignored
    send_block(3'd6, '0);
    send_block(3'd7, random_block());
    send_block(rocca_pkg::CMD_ENCRYPT, random_block());
    wait_drained();
    load_key_nonce('1, 1'b0);
    send_block(rocca_pkg::CMD_FINALIZE, '0);   // new registers are not used until init
    send_block(rocca_pkg::CMD_INIT, random_block());
    send_block(rocca_pkg::CMD_DECRYPT, '1);
    send_block(rocca_pkg::CMD_FINALIZE, '0);
    wait_drained();
  endtask

  // Mostly well-formed messages: usually init, some AD, message blocks with rare unknown commands, then the tag.
  task automatic test_random_messages(input int block_budget);
    int sent;
    int n_ad;
    int n_msg;
    sent = 0;
    while (sent < block_budget) begin
      if ($urandom_range(0, 3) == 0) begin
        wait_drained();
        load_key_nonce('0, 1'b1);
      end
      if ($urandom_range(0, 9) != 0) send_block(rocca_pkg::CMD_INIT, random_block());
      n_ad = $urandom_range(0, 4);
      n_msg = $urandom_range(0, 8);
      for (int i = 0; i < n_ad; i++) send_block(rocca_pkg::CMD_AD, random_block());
      for (int i = 0; i < n_msg; i++) begin
        if ($urandom_range(0, 19) == 0) send_block(3'($urandom_range(5, 7)), random_block());
        send_block($urandom_range(0, 1) ? rocca_pkg::CMD_ENCRYPT : rocca_pkg::CMD_DECRYPT,
                   random_block());
      end
      send_block(rocca_pkg::CMD_FINALIZE, random_block());
      if ($urandom_range(0, 4) == 0) send_block(rocca_pkg::CMD_FINALIZE, random_block());
      sent += n_ad + n_msg + 2;
    end
  endtask

  task automatic test_back_to_back();
    allow_stall = 1'b0;
    wait_drained();
    for (int i = 0; i < 30; i++) begin
      send_block(3'($urandom_range(1, 4)), random_block());
    end
    allow_stall = 1'b1;
  endtask

  // Result checker with a receiver that stalls at random while stalls are allowed.
  always @(posedge clk) begin
    cipher_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result kind=%0d data=%h", $time, out_tuser, out_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.kind) begin
          $display("%0t: result_kind expected %0d actual %0d", $time, want.kind, out_tuser);
          error_count++;
        end
        for (int w = 0; w < 4; w++) begin
          if (out_tdata[64*w +: 64] !== want.data[64*w +: 64]) begin
            $display("%0t: out_word%0d expected %h actual %h", $time, w,
                     want.data[64*w +: 64], out_tdata[64*w +: 64]);
            error_count++;
          end
        end
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (allow_stall && $urandom_range(0, 39) == 0) begin
      stall_left <= $urandom_range(10, 40);
      out_tready <= 1'b0;
    end else if (!allow_stall || $urandom_range(0, 3) != 0) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'($urandom_range(0, 1));
    end
  end

  // Watchdog on cycles without any accepted transaction, register write or reset.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    allow_stall = 1'b1;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    for (int i = 0; i < rocca_pkg::NUM_REGS; i++) key_nonce[i] = '0;
    for (int i = 0; i < 8; i++) rstate[i] = '0;
    ad_bytes = '0;
    msg_bytes = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_before_init();
    test_directed();
    test_random_messages(235);
    test_back_to_back();
    test_random_messages(235);
    wait_drained();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
